>>> rtl/vlpu_pkg.sv
// Shared types, constants and the palette table of the video line packet unpacker.
package vlpu_pkg;

    localparam int DEF_MAX_WIDTH    = 384;
    localparam int DEF_MAX_HEIGHT   = 272;
    localparam int DEF_HEADER_BYTES = 12;

    localparam int HDR_STORE   = 12;
    localparam int HDR_IDX_W   = 4;
    localparam int COL_W       = 13;
    localparam int ADDR_W      = 17;
    localparam int DIM_W       = 9;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [15:0]      NO_FRAME      = 16'hFFFF;
    localparam logic [15:0]      LINE_SAT      = 16'hFFFF;
    localparam logic [DIM_W-1:0] RESET_HEIGHT  = 9'd272;
    localparam logic [7:0]       PIXEL_DEPTH   = 8'd4;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_PAYLOAD = 4'b0010,
        PH_IGNORE  = 4'b0100,
        PH_DONE    = 4'b1000
    } phase_t;

    typedef struct packed {
        logic             has_pixel;
        logic             has_status;
        logic [15:0]      row;
        logic [COL_W-1:0] col;
        logic [7:0]       pix_byte;
        logic             right_valid;
        logic             accepted;
        logic             ready;
        logic             complete;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } entry_t;

    function automatic logic [31:0] palette_color(input logic [3:0] idx);
        logic [31:0] c;
        case (idx)
            4'd0:    c = 32'hFF000000;
            4'd1:    c = 32'hFFFFFFFF;
            4'd2:    c = 32'hFF813338;
            4'd3:    c = 32'hFF75CEC8;
            4'd4:    c = 32'hFF8E3C97;
            4'd5:    c = 32'hFF56AC4D;
            4'd6:    c = 32'hFF2E2C9B;
            4'd7:    c = 32'hFFEDF171;
            4'd8:    c = 32'hFF8E5029;
            4'd9:    c = 32'hFF553800;
            4'd10:   c = 32'hFFC46C71;
            4'd11:   c = 32'hFF4A4A4A;
            4'd12:   c = 32'hFF7B7B7B;
            4'd13:   c = 32'hFFA9FF9F;
            4'd14:   c = 32'hFF706DEB;
            default: c = 32'hFFB2B2B2;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/vlpu_front.sv
// Front part: accepts packet bytes, parses the header, tracks frame state and queues work.
module vlpu_front
    import vlpu_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_of_packet,
    input  logic [15:0] packet_length,
    output logic        entry_push,
    output entry_t      entry
);

    logic [7:0]       hdr_reg [HDR_STORE];
    logic [15:0]      pos_reg, pos_next;
    phase_t           phase_reg, phase_next;
    logic [15:0]      frame_reg, frame_next;
    logic [15:0]      lines_reg, lines_next;
    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic             ready_reg, ready_next;
    logic             complete_reg, complete_next;
    logic [7:0]       offset_reg, offset_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [23:0]      product_reg, product_next;

    logic        accept;
    logic [15:0] ppl;
    logic [7:0]  lpp;
    logic [14:0] start_line;
    logic [15:0] frame_num;
    logic [7:0]  enc_hi;
    logic [16:0] line_end;
    logic        hdr_ok;

    assign accept     = push && !full;
    assign ppl        = {hdr_reg[7], hdr_reg[6]};
    assign lpp        = hdr_reg[8];
    assign start_line = {hdr_reg[5][6:0], hdr_reg[4]};
    assign frame_num  = {hdr_reg[3], hdr_reg[2]};
    assign enc_hi     = (pos_reg == 16'd11) ? data_byte : hdr_reg[11];
    assign line_end   = 17'(start_line) + 17'(lpp);

    always_comb
    begin
        logic [16:0] half;
        half         = (17'(ppl) + 17'd1) >> 1;
        product_next = 24'(half[15:0]) * 24'(lpp);
        hdr_ok = (hdr_reg[9] == PIXEL_DEPTH) && (hdr_reg[10] == 8'd0) && (enc_hi == 8'd0)
              && (ppl != 16'd0) && (ppl <= 16'(MAX_WIDTH)) && (lpp != 8'd0)
              && (line_end <= 17'(MAX_HEIGHT))
              && (25'(packet_length) >= 25'(HEADER_BYTES) + 25'(product_reg));
    end

    always_comb
    begin
        logic [16:0] col_plus2;
        logic [16:0] lines_sum;
        logic [15:0] lines_base;
        logic        ready_base;

        pos_next      = pos_reg;
        phase_next    = phase_reg;
        frame_next    = frame_reg;
        lines_next    = lines_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        ready_next    = ready_reg;
        complete_next = complete_reg;
        offset_next   = offset_reg;
        col_next      = col_reg;
        entry         = '0;
        entry_push    = 1'b0;
        col_plus2     = 17'(col_reg) + 17'd2;
        lines_base    = lines_reg;
        ready_base    = ready_reg;
        lines_sum     = '0;

        if (accept)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg == 16'(HEADER_BYTES - 1))
                    begin
                        if (hdr_ok)
                        begin
                            phase_next  = PH_PAYLOAD;
                            offset_next = '0;
                            col_next    = '0;
                        end
                        else
                        begin
                            phase_next = PH_IGNORE;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    entry.has_pixel   = 1'b1;
                    entry.row         = 16'(start_line) + 16'(offset_reg);
                    entry.col         = col_reg;
                    entry.pix_byte    = data_byte;
                    entry.right_valid = (17'(col_reg) + 17'd1) < 17'(ppl);
                    col_next          = col_plus2[COL_W-1:0];
                    if (col_plus2 >= 17'(ppl))
                    begin
                        col_next    = '0;
                        offset_next = offset_reg + 8'd1;
                        if (9'(offset_reg) + 9'd1 >= 9'(lpp))
                        begin
                            if (frame_num != frame_reg)
                            begin
                                lines_base = '0;
                                ready_base = 1'b0;
                            end
                            frame_next = frame_num;
                            lines_sum  = 17'(lines_base) + 17'(lpp);
                            lines_next = lines_sum[16] ? LINE_SAT : lines_sum[15:0];
                            width_next = ppl[DIM_W-1:0];
                            ready_next = ready_base;
                            if (hdr_reg[5][7])
                            begin
                                height_next   = line_end[DIM_W-1:0];
                                ready_next    = 1'b1;
                                complete_next = 17'(lines_next) >= line_end;
                            end
                            phase_next = PH_DONE;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (pos_reg != 16'hFFFF)
            begin
                pos_next = pos_reg + 16'd1;
            end

            if (end_of_packet)
            begin
                entry.has_status = 1'b1;
                entry.accepted   = (phase_next == PH_DONE);
                entry.ready      = (phase_next == PH_DONE) && ready_next;
                entry.complete   = complete_next;
                entry.width      = width_next;
                entry.height     = height_next;
                pos_next         = '0;
                phase_next       = PH_HEADER;
                offset_next      = '0;
                col_next         = '0;
            end

            entry_push = entry.has_pixel || entry.has_status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (phase_reg == PH_HEADER))
        begin
            product_reg <= product_next;
            if (pos_reg < 16'(HDR_STORE))
            begin
                hdr_reg[pos_reg[HDR_IDX_W-1:0]] <= data_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            phase_reg    <= PH_HEADER;
            frame_reg    <= NO_FRAME;
            lines_reg    <= '0;
            width_reg    <= DIM_W'(MAX_WIDTH);
            height_reg   <= RESET_HEIGHT;
            ready_reg    <= 1'b0;
            complete_reg <= 1'b0;
            offset_reg   <= '0;
            col_reg      <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            phase_reg    <= phase_next;
            frame_reg    <= frame_next;
            lines_reg    <= lines_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            ready_reg    <= ready_next;
            complete_reg <= complete_next;
            offset_reg   <= offset_next;
            col_reg      <= col_next;
        end
    end

endmodule

>>> rtl/vlpu_queue.sv
// Short queue of work words between the front and back parts.
module vlpu_queue
    import vlpu_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  entry_t wr_data,
    output logic   full,
    input  logic   rd_en,
    output entry_t rd_data,
    output logic   empty
);

    entry_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_wr;
    logic              do_rd;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/vlpu_back.sv
// Back part: expands queued work into pixel writes and status reports in an output register.
module vlpu_back
    import vlpu_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  entry_t            head,
    input  logic              head_valid,
    output logic              deq,
    input  logic              pop,
    output logic              empty,
    output logic              result_kind,
    output logic [ADDR_W-1:0] pixel_address,
    output logic [31:0]       left_color,
    output logic [31:0]       right_color,
    output logic              right_valid,
    output logic              packet_accepted,
    output logic              frame_ready,
    output logic              frame_complete,
    output logic [DIM_W-1:0]  frame_width,
    output logic [DIM_W-1:0]  frame_height,
    output logic              last_of_run
);

    localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(MAX_WIDTH);

    logic              valid_reg, valid_next;
    logic              half_reg, half_next;
    logic              kind_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [31:0]       left_reg;
    logic [31:0]       right_reg;
    logic              rvalid_reg;
    logic              acc_reg;
    logic              ready_reg;
    logic              complete_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic              last_reg;
    logic              load;
    logic              take_pixel;
    logic [ADDR_W-1:0] addr_calc;

    assign load       = head_valid && (!valid_reg || pop);
    assign take_pixel = head.has_pixel && !half_reg;
    assign deq        = load && (!take_pixel || !head.has_status);
    assign addr_calc  = ADDR_W'(ADDR_W'(head.row) * ROW_STEP) + ADDR_W'(head.col);

    always_comb
    begin
        half_next  = half_reg;
        valid_next = valid_reg;
        if (load)
        begin
            half_next  = take_pixel && head.has_status;
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (take_pixel)
            begin
                kind_reg     <= KIND_PIXEL;
                addr_reg     <= addr_calc;
                left_reg     <= palette_color(head.pix_byte[3:0]);
                right_reg    <= palette_color(head.pix_byte[7:4]);
                rvalid_reg   <= head.right_valid;
                acc_reg      <= 1'b0;
                ready_reg    <= 1'b0;
                complete_reg <= 1'b0;
                width_reg    <= '0;
                height_reg   <= '0;
                last_reg     <= !head.has_status;
            end
            else
            begin
                kind_reg     <= KIND_STATUS;
                addr_reg     <= '0;
                left_reg     <= '0;
                right_reg    <= '0;
                rvalid_reg   <= 1'b0;
                acc_reg      <= head.accepted;
                ready_reg    <= head.ready;
                complete_reg <= head.complete;
                width_reg    <= head.width;
                height_reg   <= head.height;
                last_reg     <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    assign empty           = !valid_reg;
    assign result_kind     = kind_reg;
    assign pixel_address   = addr_reg;
    assign left_color      = left_reg;
    assign right_color     = right_reg;
    assign right_valid     = rvalid_reg;
    assign packet_accepted = acc_reg;
    assign frame_ready     = ready_reg;
    assign frame_complete  = complete_reg;
    assign frame_width     = width_reg;
    assign frame_height    = height_reg;
    assign last_of_run     = last_reg;

endmodule

>>> rtl/video_line_packet_unpacker_core.sv
// Top level of the video line packet unpacker.
// Input side: one packet byte per word with its end mark and the packet length;
// a word is taken when push is high and full is low. Header bytes come first,
// then payload; every byte of a packet carries the same packet length.
// Result side: each payload byte of an accepted layout gives one pixel pair write,
// and the final byte of a packet also gives a status report; last_of_run marks the
// final result of a byte. A result is shown while empty is low and taken on pop.
// The first result of a byte reaches the result ports through the queue and then
// the result register. Throughput: one byte per cycle as long as results drain;
// a payload byte that carries the end mark gives two results, the pixel pair
// write first and then the status report.
// The front stage and the result register are joined by a four-word queue, so a
// stalled receiver first fills the queue and then raises full; nothing is lost.
// Reset clears the packet parser, frame state and queue; the frame size kept for
// status reports returns to its defaults and no frame is current.
module video_line_packet_unpacker_core
    import vlpu_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        data_byte,
    input  logic              end_of_packet,
    input  logic [15:0]       packet_length,
    output logic              empty,
    input  logic              pop,
    output logic              result_kind,
    output logic [ADDR_W-1:0] pixel_address,
    output logic [31:0]       left_color,
    output logic [31:0]       right_color,
    output logic              right_valid,
    output logic              packet_accepted,
    output logic              frame_ready,
    output logic              frame_complete,
    output logic [DIM_W-1:0]  frame_width,
    output logic [DIM_W-1:0]  frame_height,
    output logic              last_of_run
);

    entry_t wr_entry;
    entry_t head;
    logic   wr_en;
    logic   q_empty;
    logic   deq;

    vlpu_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .end_of_packet (end_of_packet),
        .packet_length (packet_length),
        .entry_push    (wr_en),
        .entry         (wr_entry)
    );

    vlpu_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_entry),
        .full    (full),
        .rd_en   (deq),
        .rd_data (head),
        .empty   (q_empty)
    );

    vlpu_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .head_valid      (!q_empty),
        .deq             (deq),
        .pop             (pop),
        .empty           (empty),
        .result_kind     (result_kind),
        .pixel_address   (pixel_address),
        .left_color      (left_color),
        .right_color     (right_color),
        .right_valid     (right_valid),
        .packet_accepted (packet_accepted),
        .frame_ready     (frame_ready),
        .frame_complete  (frame_complete),
        .frame_width     (frame_width),
        .frame_height    (frame_height),
        .last_of_run     (last_of_run)
    );

endmodule
